// File: rtl/oamsc_pkg.sv
package oamsc_pkg;

    localparam int NUM_ROWS  = 20;
    localparam int ROW_AW    = $clog2(NUM_ROWS);
    localparam int ROW_BITS  = 64;
    localparam int RW_LO_ROW = 4;
    localparam int RW_HI_ROW = 19;

    localparam logic [7:0] REGION_HI  = 8'hFE;
    localparam logic [7:0] STORE_LIM  = 8'hA0;
    localparam logic [7:0] BYTE_OPEN  = 8'hFF;

    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_CORRUPT = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_RW    = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ,
        OP_WRITE,
        OP_CORR,
        OP_CORR_RW
    } t_op;

    typedef enum logic [1:0] {
        SLOT_M2,
        SLOT_M1,
        SLOT_CUR
    } t_slot;

    typedef struct packed {
        logic  latch;
        logic  rd_en;
        t_slot rd_slot;
        logic  wr_en;
        t_slot wr_slot;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        t_op in_op;
        t_op op;
    } t_status;

endpackage

// File: rtl/oam_scan_corruption_store_unit.sv
// Sprite attribute store, 20 rows x 8 bytes, with the scan-time corruption rules.
// Input channel: i_valid / o_stall plus the item fields; a transaction is taken
// on a rising edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall with o_read_data and o_corrupted, one result per input transaction.
// Actions: byte read, byte write (0xFE00..0xFE9F), corruption event.
// One item is worked on at a time; the pace is set by the row store, which
// has separate read and write ports but is driven like a single port: one
// row read or written per cycle, never both, read data registered. The next
// transaction is taken the cycle after the result loads.
// The output register lets the next transaction be accepted while a result
// is still waiting; a new result is only loaded once the old one is taken,
// so a stalling receiver holds the block in its final step.
// Reset (synchronous, active low) empties the channels and marks every row
// unwritten; unwritten rows read as zero, so the store starts all zero with
// no clearing pass.
module oam_scan_corruption_store_unit
    import oamsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_corruption_kind,
    input  logic        i_in_oam_scan,
    input  logic [5:0]  i_sprites_scanned,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_corrupted
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: decides the row read/write steps for each transaction
    oamsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: decode, row images, corruption rules, row store, result regs
    oamsc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_action          (i_action),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_corruption_kind (i_corruption_kind),
        .i_in_oam_scan     (i_in_oam_scan),
        .i_sprites_scanned (i_sprites_scanned),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_read_data       (o_read_data),
        .o_corrupted       (o_corrupted)
    );

endmodule

// File: rtl/oamsc_ram.sv
module oamsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/oamsc_dp.sv
module oamsc_dp
    import oamsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_corruption_kind,
    input  logic        i_in_oam_scan,
    input  logic [5:0]  i_sprites_scanned,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [7:0]  o_read_data,
    output logic        o_corrupted
);

    // latched transaction
    t_op               r_op;
    logic [ROW_AW-1:0] r_row;
    logic [2:0]        r_byte;
    logic [7:0]        r_wdata;
    logic              r_kind_wr;

    // row images: scan row minus two, minus one, and the addressed row
    logic [ROW_BITS-1:0] r_m2, r_m1, r_cur;

    logic [NUM_ROWS-1:0] r_vld;
    logic                r_cap_en;
    t_slot               r_cap_slot;
    logic                r_cap_vld;

    logic [7:0] r_rd_data;
    logic       r_corr;

    logic                in_store, in_region, corr_ok, rw_range;
    logic [ROW_AW-1:0]   srow, in_row, rd_addr, wr_addr;
    t_op                 in_op;
    logic [ROW_BITS-1:0] ram_rdata, cap_data, wr_data, merged, p_row;
    logic [15:0]         p_w, wrule, rrule;

    // ---------------- item decode ----------------
    assign srow      = i_sprites_scanned[5:1];
    assign in_region = (i_address[15:8] == REGION_HI);
    assign in_store  = in_region && (i_address[7:0] < STORE_LIM);
    assign corr_ok   = i_in_oam_scan && in_region && (srow != '0)
                       && (srow < ROW_AW'(NUM_ROWS))
                       && ((i_corruption_kind == KIND_WRITE)
                           || (i_corruption_kind == KIND_READ)
                           || (i_corruption_kind == KIND_RW));
    assign rw_range  = (srow >= ROW_AW'(RW_LO_ROW)) && (srow < ROW_AW'(RW_HI_ROW));
    assign in_row    = (i_action == ACT_CORRUPT) ? srow : i_address[7:3];

    always_comb begin
        in_op = OP_NOP;
        unique case (i_action)
            ACT_READ:    if (in_store) in_op = OP_READ;
            ACT_WRITE:   if (in_store) in_op = OP_WRITE;
            ACT_CORRUPT: begin
                if (corr_ok) begin
                    in_op = (i_corruption_kind == KIND_RW && rw_range) ? OP_CORR_RW : OP_CORR;
                end
            end
            default:     in_op = OP_NOP;
        endcase
    end

    assign o_status.in_op = in_op;
    assign o_status.op    = r_op;

    // ---------------- row arithmetic ----------------
    assign p_w   = (r_m1[15:0] & (r_m2[15:0] | r_cur[15:0] | r_m1[47:32]))
                 | (r_m2[15:0] & r_cur[15:0] & r_m1[47:32]);
    assign p_row = {r_m1[63:16], p_w};
    assign wrule = ((r_cur[15:0] ^ r_m1[47:32]) & (r_m1[15:0] ^ r_m1[47:32])) ^ r_m1[47:32];
    assign rrule = r_m1[15:0] | (r_cur[15:0] & r_m1[47:32]);

    always_comb begin
        merged = r_cur;
        merged[{r_byte, 3'b000} +: 8] = r_wdata;
    end

    always_comb begin
        case (i_cmd.wr_slot)
            SLOT_M1: wr_data = p_row;
            SLOT_M2: wr_data = r_m1;
            default: begin
                if (r_op == OP_WRITE) begin
                    wr_data = merged;
                end else begin
                    wr_data = {r_m1[63:16], r_kind_wr ? wrule : rrule};
                end
            end
        endcase
    end

    function automatic logic [ROW_AW-1:0] slot_row(t_slot s, logic [ROW_AW-1:0] row);
        logic [ROW_AW-1:0] res;
        case (s)
            SLOT_M2: res = row - ROW_AW'(2);
            SLOT_M1: res = row - ROW_AW'(1);
            default: res = row;
        endcase
        return res;
    endfunction

    assign rd_addr = slot_row(i_cmd.rd_slot, r_row);
    assign wr_addr = slot_row(i_cmd.wr_slot, r_row);

    oamsc_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(NUM_ROWS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    // rows never written since reset read as zero
    assign cap_data = r_cap_vld ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_cap_en <= 1'b0;
            r_op     <= OP_NOP;
        end else begin
            r_cap_en <= i_cmd.rd_en;
            if (i_cmd.wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_op <= in_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_slot <= i_cmd.rd_slot;
        r_cap_vld  <= r_vld[rd_addr];
        if (i_cmd.latch) begin
            r_row     <= in_row;
            r_byte    <= i_address[2:0];
            r_wdata   <= i_write_data;
            r_kind_wr <= (i_corruption_kind == KIND_WRITE);
        end
        if (r_cap_en) begin
            case (r_cap_slot)
                SLOT_M2: r_m2  <= cap_data;
                SLOT_M1: r_m1  <= cap_data;
                default: r_cur <= cap_data;
            endcase
        end else if (i_cmd.wr_en && i_cmd.wr_slot == SLOT_M1) begin
            // read-write rule: the merged row lands in r-2, r-1 and r
            r_m1  <= p_row;
            r_cur <= p_row;
        end
        if (i_cmd.out_load) begin
            r_rd_data <= (r_op == OP_READ) ? r_cur[{r_byte, 3'b000} +: 8] : BYTE_OPEN;
            r_corr    <= (r_op == OP_CORR) || (r_op == OP_CORR_RW);
        end
    end

    assign o_read_data = r_rd_data;
    assign o_corrupted = r_corr;

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (wr_addr < ROW_AW'(NUM_ROWS)))
        else $error("store write outside the row range");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (rd_addr < ROW_AW'(NUM_ROWS)))
        else $error("store read outside the row range");

    a_rw_row_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wr_slot == SLOT_M2) |-> (r_row >= ROW_AW'(RW_LO_ROW)))
        else $error("read-write copy below its row window");

endmodule

// File: rtl/oamsc_ctrl.sv
module oamsc_ctrl
    import oamsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_M2,
        S_RD_M1,
        S_RD_CUR,
        S_CAP,
        S_RW_WR1,
        S_RW_WR2,
        S_WR_CUR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   accept, load;

    assign accept = i_valid && (r_state == S_IDLE);
    assign load   = (r_state == S_DONE) && (!r_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_status.in_op)
                        OP_READ, OP_WRITE: n_state = S_RD_CUR;
                        OP_CORR:           n_state = S_RD_M1;
                        OP_CORR_RW:        n_state = S_RD_M2;
                        default:           n_state = S_DONE;
                    endcase
                end
            end
            S_RD_M2:  n_state = S_RD_M1;
            S_RD_M1:  n_state = S_RD_CUR;
            S_RD_CUR: n_state = S_CAP;
            S_CAP: begin
                unique case (i_status.op)
                    OP_READ:    n_state = S_DONE;
                    OP_CORR_RW: n_state = S_RW_WR1;
                    default:    n_state = S_WR_CUR;
                endcase
            end
            S_RW_WR1: n_state = S_RW_WR2;
            S_RW_WR2: n_state = S_WR_CUR;
            S_WR_CUR: n_state = S_DONE;
            S_DONE:   if (load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign n_valid = load || (r_valid && i_stall);

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_slot  = SLOT_CUR;
        o_cmd.wr_slot  = SLOT_CUR;
        o_cmd.latch    = accept;
        o_cmd.out_load = load;
        unique case (r_state)
            S_RD_M2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_slot = SLOT_M2;
            end
            S_RD_M1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_slot = SLOT_M1;
            end
            S_RD_CUR: o_cmd.rd_en = 1'b1;
            S_RW_WR1: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_slot = SLOT_M1;
            end
            S_RW_WR2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_slot = SLOT_M2;
            end
            S_WR_CUR: o_cmd.wr_en = 1'b1;
            default:  o_cmd.rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("store read and write issued together");

    a_nop_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.in_op == OP_NOP) |=> (r_state == S_DONE))
        else $error("no-effect transaction took the long path");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_valid && r_state == S_IDLE))
        else $error("result load did not raise output valid");

endmodule
